// File: rtl/dbht_pkg.sv
package dbht_pkg;

    localparam int PIN_W   = 4;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;
    localparam int QUERY_W = 2;
    localparam int CFG_W   = 8;
    localparam int ADDR_W  = 1;

    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [ADDR_W-1:0] REG_MASK      = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_SEED   = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd3;
    localparam logic [PIN_W-1:0] MASK_RESET      = 4'hF;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] since;
    } lane_out_t;

endpackage

// File: rtl/multi_input_debounce_with_hold_timer_core.sv
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless an unread result stalls the input;
// channel lanes update on accept; one output register holds the merged result.
// Reset: all lanes clear to inactive, the threshold returns to three and the
// active-low mask to all ones; no clearing pass is needed.
module multi_input_debounce_with_hold_timer_core
#(
    parameter int CHANNELS = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [dbht_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [dbht_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [dbht_pkg::PIN_W-1:0]     raw_pins,
    input  logic [dbht_pkg::TIME_W-1:0]    now_ms,
    input  logic [dbht_pkg::QUERY_W-1:0]   query_channel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dbht_pkg::PIN_W-1:0]     stable_levels,
    output logic                           query_active,
    output logic [dbht_pkg::TIME_W-1:0]    query_duration_ms
);

    logic [dbht_pkg::CNT_W-1:0] threshold_reg;
    logic [dbht_pkg::PIN_W-1:0] mask_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       accept;
    logic [CHANNELS-1:0]        samples;
    logic [dbht_pkg::PIN_W-1:0] logical_pins;
    dbht_pkg::lane_out_t        lanes [CHANNELS];

    assign in_ready     = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign logical_pins = raw_pins ^ mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= dbht_pkg::THRESHOLD_RESET;
            mask_reg      <= dbht_pkg::MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                dbht_pkg::REG_THRESHOLD: threshold_reg <= cfg_wdata;
                dbht_pkg::REG_MASK:      mask_reg <= cfg_wdata[dbht_pkg::PIN_W-1:0];
                default:                 threshold_reg <= threshold_reg;
            endcase
        end
    end

    generate
        for (genvar g = 0; g < CHANNELS; g++)
        begin : g_lane
            if (g < dbht_pkg::PIN_W)
            begin : g_pin
                assign samples[g] = logical_pins[g];
            end
            else
            begin : g_nopin
                assign samples[g] = 1'b0;
            end

            dbht_lane u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .accept    (accept),
                .cmd       (cmd),
                .sample    (samples[g]),
                .now_ms    (now_ms),
                .threshold (threshold_reg),
                .lane_next (lanes[g])
            );
        end
    endgenerate

    dbht_merge #(.CHANNELS(CHANNELS)) u_merge
    (
        .clk               (clk),
        .load              (accept),
        .lanes             (lanes),
        .now_ms            (now_ms),
        .query_channel     (query_channel),
        .stable_levels     (stable_levels),
        .query_active      (query_active),
        .query_duration_ms (query_duration_ms)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted item produced no result");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !query_active |-> query_duration_ms == '0)
        else $error("inactive channel reports a nonzero duration");

    a_seed_levels: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == dbht_pkg::CMD_SEED |=>
            stable_levels == $past(samples[0] ? logical_pins & logical_pins
                                              : logical_pins) || CHANNELS < dbht_pkg::PIN_W)
        else $error("seed did not load the stable levels from the pins");

    a_seed_duration: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == dbht_pkg::CMD_SEED |=> query_duration_ms == '0)
        else $error("seeded channel reports a nonzero duration");

endmodule

// File: rtl/dbht_lane.sv
module dbht_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          cmd,
    input  logic                          sample,
    input  logic [dbht_pkg::TIME_W-1:0]   now_ms,
    input  logic [dbht_pkg::CNT_W-1:0]    threshold,
    output dbht_pkg::lane_out_t           lane_next
);

    logic                        stable_reg;
    logic                        stable_next;
    logic                        cand_reg;
    logic                        cand_next;
    logic [dbht_pkg::CNT_W-1:0]  count_reg;
    logic [dbht_pkg::CNT_W-1:0]  count_next;
    logic [dbht_pkg::TIME_W-1:0] since_reg;
    logic [dbht_pkg::TIME_W-1:0] since_next;
    logic [dbht_pkg::CNT_W-1:0]  count_trial;
    logic [dbht_pkg::TIME_W-1:0] since_fresh;

    assign since_fresh = sample ? now_ms : '0;

    always_comb
    begin
        stable_next = stable_reg;
        cand_next   = cand_reg;
        count_next  = count_reg;
        since_next  = since_reg;
        count_trial = 8'd1;
        if (cmd == dbht_pkg::CMD_SEED)
        begin
            stable_next = sample;
            cand_next   = sample;
            count_next  = '0;
            since_next  = since_fresh;
        end
        else if (sample == stable_reg)
        begin
            cand_next  = sample;
            count_next = '0;
        end
        else
        begin
            if (sample == cand_reg)
            begin
                count_trial = (count_reg == dbht_pkg::CNT_MAX) ? count_reg
                                                               : count_reg + 8'd1;
            end
            cand_next = sample;
            if (count_trial >= threshold)
            begin
                stable_next = sample;
                count_next  = '0;
                since_next  = since_fresh;
            end
            else
            begin
                count_next = count_trial;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            cand_reg   <= 1'b0;
            count_reg  <= '0;
            since_reg  <= '0;
        end
        else if (accept)
        begin
            stable_reg <= stable_next;
            cand_reg   <= cand_next;
            count_reg  <= count_next;
            since_reg  <= since_next;
        end
    end

    assign lane_next.level = stable_next;
    assign lane_next.since = since_next;

endmodule

// File: rtl/dbht_merge.sv
module dbht_merge
#(
    parameter int CHANNELS = 4
)
(
    input  logic                           clk,
    input  logic                           load,
    input  dbht_pkg::lane_out_t            lanes [CHANNELS],
    input  logic [dbht_pkg::TIME_W-1:0]    now_ms,
    input  logic [dbht_pkg::QUERY_W-1:0]   query_channel,
    output logic [dbht_pkg::PIN_W-1:0]     stable_levels,
    output logic                           query_active,
    output logic [dbht_pkg::TIME_W-1:0]    query_duration_ms
);

    logic [dbht_pkg::PIN_W-1:0]  levels_reg;
    logic [dbht_pkg::PIN_W-1:0]  levels_next;
    logic                        active_reg;
    logic                        active_next;
    logic [dbht_pkg::TIME_W-1:0] duration_reg;
    logic [dbht_pkg::TIME_W-1:0] duration_next;
    logic [dbht_pkg::TIME_W-1:0] since_sel;

    always_comb
    begin
        levels_next = '0;
        active_next = 1'b0;
        since_sel   = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (i < dbht_pkg::PIN_W)
            begin
                levels_next[i] = lanes[i].level;
                if (query_channel == dbht_pkg::QUERY_W'(i))
                begin
                    active_next = lanes[i].level;
                    since_sel   = lanes[i].since;
                end
            end
        end
        duration_next = active_next ? (now_ms - since_sel) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            levels_reg   <= levels_next;
            active_reg   <= active_next;
            duration_reg <= duration_next;
        end
    end

    assign stable_levels     = levels_reg;
    assign query_active      = active_reg;
    assign query_duration_ms = duration_reg;

endmodule
